>>> design/dmac_pkg.sv
// Shared constants, types and state codes for the moving average crossover unit.
package dmac_pkg;

    localparam int MAX_WINDOW = 256;
    localparam int PRICE_BITS = 24;
    localparam int TAG_BITS = 32;
    localparam int LEN_BITS = 9;
    localparam int PTR_BITS = $clog2(MAX_WINDOW);
    localparam int EFF_BITS = PTR_BITS + 1;
    localparam int CMP_BITS = (LEN_BITS > EFF_BITS) ? LEN_BITS : EFF_BITS;
    localparam int SUM_BITS = PRICE_BITS + PTR_BITS;
    localparam int DIGIT_BITS = 2;
    localparam int DIV_CYCLES = (SUM_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int DIV_BITS = DIV_CYCLES * DIGIT_BITS;
    localparam int DIV_CNT_BITS = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SHORT_LEN = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_LEN = CFG_INDEX_BITS'(1);

    localparam logic [LEN_BITS-1:0] SHORT_LEN_RESET = LEN_BITS'(50);
    localparam logic [LEN_BITS-1:0] LONG_LEN_RESET = LEN_BITS'(200);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_SHORT,
        ST_READ_LONG,
        ST_UPDATE,
        ST_START,
        ST_DIV_SHORT,
        ST_DIV_LONG,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic restart;
        logic rd_short;
        logic rd_long;
        logic update;
    } win_ctl_t;

    typedef struct packed {
        logic full;
    } win_stat_t;

endpackage

>>> design/dmac_serial_div.sv
// Shared restoring divider that retires two quotient bits per cycle.
module dmac_serial_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [dmac_pkg::SUM_BITS-1:0] dividend,
    input  logic [dmac_pkg::EFF_BITS-1:0] divisor,
    output logic                          done,
    output logic [dmac_pkg::SUM_BITS-1:0] quotient,
    output logic [dmac_pkg::EFF_BITS-1:0] remainder
);

    logic [dmac_pkg::DIV_BITS-1:0]     work_reg;
    logic [dmac_pkg::DIV_BITS-1:0]     work_next;
    logic [dmac_pkg::EFF_BITS-1:0]     rem_reg;
    logic [dmac_pkg::EFF_BITS-1:0]     rem_next;
    logic [dmac_pkg::EFF_BITS-1:0]     dsr_reg;
    logic [dmac_pkg::DIV_CNT_BITS-1:0] cnt_reg;
    logic                              busy_reg;
    logic                              done_reg;

    // The dividend shifts out of the top of the work register while quotient
    // bits shift in at the bottom.
    always_comb
    begin
        logic [dmac_pkg::EFF_BITS:0] trial;
        work_next = work_reg;
        rem_next = rem_reg;
        for (int i = 0; i < dmac_pkg::DIGIT_BITS; i++)
        begin
            trial = {rem_next, work_next[dmac_pkg::DIV_BITS-1]};
            work_next = {work_next[dmac_pkg::DIV_BITS-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                trial = trial - {1'b0, dsr_reg};
                work_next[0] = 1'b1;
            end
            rem_next = trial[dmac_pkg::EFF_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == dmac_pkg::DIV_CNT_BITS'(dmac_pkg::DIV_CYCLES - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dmac_pkg::DIV_BITS'(dividend);
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quotient = work_reg[dmac_pkg::SUM_BITS-1:0];
    assign remainder = rem_reg;

endmodule

>>> design/dmac_window.sv
// Price history ring with the running short and long window sums.
module dmac_window (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dmac_pkg::win_ctl_t              ctl,
    input  logic [dmac_pkg::PRICE_BITS-1:0] price,
    input  logic [dmac_pkg::EFF_BITS-1:0]   s_len,
    input  logic [dmac_pkg::EFF_BITS-1:0]   l_len,
    output logic [dmac_pkg::SUM_BITS-1:0]   short_sum,
    output logic [dmac_pkg::SUM_BITS-1:0]   long_sum,
    output dmac_pkg::win_stat_t             stat
);

    logic [dmac_pkg::PRICE_BITS-1:0] hist_mem [dmac_pkg::MAX_WINDOW];
    logic [dmac_pkg::PRICE_BITS-1:0] rd_data_reg;
    logic [dmac_pkg::PRICE_BITS-1:0] old_short_reg;
    logic [dmac_pkg::PTR_BITS-1:0]   wp_reg;
    logic [dmac_pkg::PTR_BITS-1:0]   wp_next;
    logic [dmac_pkg::EFF_BITS-1:0]   fill_reg;
    logic [dmac_pkg::EFF_BITS-1:0]   fill_next;
    logic [dmac_pkg::SUM_BITS-1:0]   short_sum_reg;
    logic [dmac_pkg::SUM_BITS-1:0]   short_sum_next;
    logic [dmac_pkg::SUM_BITS-1:0]   long_sum_reg;
    logic [dmac_pkg::SUM_BITS-1:0]   long_sum_next;
    logic [dmac_pkg::EFF_BITS-1:0]   rd_len;
    logic [dmac_pkg::EFF_BITS-1:0]   back_diff;
    logic [dmac_pkg::EFF_BITS-1:0]   back_wrap;
    logic [dmac_pkg::PTR_BITS-1:0]   rd_addr;
    logic [dmac_pkg::PRICE_BITS-1:0] short_drop;
    logic [dmac_pkg::PRICE_BITS-1:0] long_drop;

    // Entry that leaves a window lies len places behind the write pointer.
    always_comb
    begin
        rd_len = ctl.rd_long ? l_len : s_len;
        back_diff = {1'b0, wp_reg} - rd_len;
        back_wrap = back_diff + dmac_pkg::EFF_BITS'(dmac_pkg::MAX_WINDOW);
        if ({1'b0, wp_reg} >= rd_len)
        begin
            rd_addr = back_diff[dmac_pkg::PTR_BITS-1:0];
        end
        else
        begin
            rd_addr = back_wrap[dmac_pkg::PTR_BITS-1:0];
        end
    end

    // The fill count guarantees that only entries written since the last
    // restart are ever subtracted.
    always_comb
    begin
        short_drop = (fill_reg >= s_len) ? old_short_reg : '0;
        long_drop = (fill_reg >= l_len) ? rd_data_reg : '0;
        short_sum_next = short_sum_reg - dmac_pkg::SUM_BITS'(short_drop)
                         + dmac_pkg::SUM_BITS'(price);
        long_sum_next = long_sum_reg - dmac_pkg::SUM_BITS'(long_drop)
                        + dmac_pkg::SUM_BITS'(price);
        fill_next = (fill_reg < l_len) ? fill_reg + 1'b1 : fill_reg;
        if (wp_reg == dmac_pkg::PTR_BITS'(dmac_pkg::MAX_WINDOW - 1))
        begin
            wp_next = '0;
        end
        else
        begin
            wp_next = wp_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.update)
        begin
            hist_mem[wp_reg] <= price;
        end
        if (ctl.rd_short || ctl.rd_long)
        begin
            rd_data_reg <= hist_mem[rd_addr];
        end
        if (ctl.rd_long)
        begin
            old_short_reg <= rd_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            fill_reg <= '0;
            short_sum_reg <= '0;
            long_sum_reg <= '0;
        end
        else if (ctl.restart)
        begin
            wp_reg <= '0;
            fill_reg <= '0;
            short_sum_reg <= '0;
            long_sum_reg <= '0;
        end
        else if (ctl.update)
        begin
            wp_reg <= wp_next;
            fill_reg <= fill_next;
            short_sum_reg <= short_sum_next;
            long_sum_reg <= long_sum_next;
        end
    end

    assign short_sum = short_sum_reg;
    assign long_sum = long_sum_reg;
    assign stat.full = (fill_reg >= l_len);

endmodule

>>> design/dual_moving_average_crossover_unit.sv
// Top level of the dual moving average crossover unit with sequencer and result register.
// A price that yields a result goes through the read, update and start states, both divisions
// and the decide state, which waits while an earlier result is held. The next price is taken
// back in idle; the shared two-bit-per-cycle divider runs once per window. Prices that still
// fill the window go back to idle after the start state. Reset restores the lengths to 50 and
// 200 and empties the stream; history is not cleared, since no stale entry is ever subtracted.
module dual_moving_average_crossover_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [dmac_pkg::PRICE_BITS-1:0]     close_price,
    input  logic [dmac_pkg::TAG_BITS-1:0]       tag,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [dmac_pkg::PRICE_BITS-1:0]     short_average,
    output logic [dmac_pkg::PRICE_BITS-1:0]     long_average,
    output logic                                buy_signal,
    output logic [dmac_pkg::TAG_BITS-1:0]       out_tag,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dmac_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dmac_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    dmac_pkg::state_t                state_reg;
    dmac_pkg::state_t                state_next;
    dmac_pkg::win_ctl_t              win_ctl;
    dmac_pkg::win_stat_t             win_stat;

    logic [dmac_pkg::LEN_BITS-1:0]   short_len_reg;
    logic [dmac_pkg::LEN_BITS-1:0]   long_len_reg;
    logic [dmac_pkg::PRICE_BITS-1:0] price_reg;
    logic [dmac_pkg::TAG_BITS-1:0]   tag_reg;
    logic [dmac_pkg::SUM_BITS-1:0]   qa_reg;
    logic [dmac_pkg::EFF_BITS-1:0]   ra_reg;
    logic [dmac_pkg::SUM_BITS-1:0]   qb_reg;
    logic [dmac_pkg::EFF_BITS-1:0]   rb_reg;
    logic                            out_valid_reg;
    logic [dmac_pkg::PRICE_BITS-1:0] short_avg_reg;
    logic [dmac_pkg::PRICE_BITS-1:0] long_avg_reg;
    logic                            buy_reg;
    logic                            buy_next;
    logic [dmac_pkg::TAG_BITS-1:0]   out_tag_reg;

    logic [dmac_pkg::CMP_BITS-1:0]   long_w;
    logic [dmac_pkg::CMP_BITS-1:0]   short_w;
    logic [dmac_pkg::CMP_BITS-1:0]   l_w;
    logic [dmac_pkg::CMP_BITS-1:0]   s_w;
    logic [dmac_pkg::EFF_BITS-1:0]   l_eff;
    logic [dmac_pkg::EFF_BITS-1:0]   s_eff;

    logic [dmac_pkg::SUM_BITS-1:0]   short_sum;
    logic [dmac_pkg::SUM_BITS-1:0]   long_sum;
    logic                            div_start;
    logic                            div_sel_long;
    logic                            div_done;
    logic [dmac_pkg::SUM_BITS-1:0]   div_quot;
    logic [dmac_pkg::EFF_BITS-1:0]   div_rem;
    logic [dmac_pkg::SUM_BITS-1:0]   div_dividend;
    logic [dmac_pkg::EFF_BITS-1:0]   div_divisor;
    logic                            cap_short;
    logic                            cap_long;
    logic                            out_load;
    logic                            in_beat;
    logic                            cfg_beat;
    logic [2*dmac_pkg::EFF_BITS-1:0] cross_a;
    logic [2*dmac_pkg::EFF_BITS-1:0] cross_b;

    assign in_beat = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_beat = cfg_valid && cfg_ready;

    // Effective lengths: long is held to 1..MAX_WINDOW, short to 1..long.
    always_comb
    begin
        long_w = dmac_pkg::CMP_BITS'(long_len_reg);
        short_w = dmac_pkg::CMP_BITS'(short_len_reg);
        if (long_w == '0)
        begin
            l_w = dmac_pkg::CMP_BITS'(1);
        end
        else if (long_w > dmac_pkg::CMP_BITS'(dmac_pkg::MAX_WINDOW))
        begin
            l_w = dmac_pkg::CMP_BITS'(dmac_pkg::MAX_WINDOW);
        end
        else
        begin
            l_w = long_w;
        end
        if (short_w == '0)
        begin
            s_w = dmac_pkg::CMP_BITS'(1);
        end
        else if (short_w > l_w)
        begin
            s_w = l_w;
        end
        else
        begin
            s_w = short_w;
        end
        l_eff = l_w[dmac_pkg::EFF_BITS-1:0];
        s_eff = s_w[dmac_pkg::EFF_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_len_reg <= dmac_pkg::SHORT_LEN_RESET;
            long_len_reg <= dmac_pkg::LONG_LEN_RESET;
        end
        else if (cfg_beat)
        begin
            if (cfg_index == dmac_pkg::REG_SHORT_LEN)
            begin
                short_len_reg <= cfg_data[dmac_pkg::LEN_BITS-1:0];
            end
            else if (cfg_index == dmac_pkg::REG_LONG_LEN)
            begin
                long_len_reg <= cfg_data[dmac_pkg::LEN_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dmac_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = dmac_pkg::ST_READ_SHORT;
                end
            end
            dmac_pkg::ST_READ_SHORT: state_next = dmac_pkg::ST_READ_LONG;
            dmac_pkg::ST_READ_LONG:  state_next = dmac_pkg::ST_UPDATE;
            dmac_pkg::ST_UPDATE:     state_next = dmac_pkg::ST_START;
            dmac_pkg::ST_START:
            begin
                state_next = win_stat.full ? dmac_pkg::ST_DIV_SHORT : dmac_pkg::ST_IDLE;
            end
            dmac_pkg::ST_DIV_SHORT:
            begin
                if (div_done)
                begin
                    state_next = dmac_pkg::ST_DIV_LONG;
                end
            end
            dmac_pkg::ST_DIV_LONG:
            begin
                if (div_done)
                begin
                    state_next = dmac_pkg::ST_DECIDE;
                end
            end
            dmac_pkg::ST_DECIDE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = dmac_pkg::ST_IDLE;
                end
            end
            default: state_next = dmac_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        win_ctl = '0;
        div_start = 1'b0;
        div_sel_long = 1'b0;
        cap_short = 1'b0;
        cap_long = 1'b0;
        out_load = 1'b0;
        win_ctl.restart = cfg_beat &&
                          (cfg_index == dmac_pkg::REG_SHORT_LEN ||
                           cfg_index == dmac_pkg::REG_LONG_LEN);
        case (state_reg)
            dmac_pkg::ST_IDLE:       in_ready = 1'b1;
            dmac_pkg::ST_READ_SHORT: win_ctl.rd_short = 1'b1;
            dmac_pkg::ST_READ_LONG:  win_ctl.rd_long = 1'b1;
            dmac_pkg::ST_UPDATE:     win_ctl.update = 1'b1;
            dmac_pkg::ST_START:      div_start = win_stat.full;
            dmac_pkg::ST_DIV_SHORT:
            begin
                // The long division starts in the cycle the short one finishes.
                cap_short = div_done;
                div_start = div_done;
                div_sel_long = 1'b1;
            end
            dmac_pkg::ST_DIV_LONG:   cap_long = div_done;
            dmac_pkg::ST_DECIDE:     out_load = !out_valid_reg || out_ready;
            default:                 in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dmac_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            price_reg <= close_price;
            tag_reg <= tag;
        end
        if (cap_short)
        begin
            qa_reg <= div_quot;
            ra_reg <= div_rem;
        end
        if (cap_long)
        begin
            qb_reg <= div_quot;
            rb_reg <= div_rem;
        end
    end

    dmac_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (win_ctl),
        .price     (price_reg),
        .s_len     (s_eff),
        .l_len     (l_eff),
        .short_sum (short_sum),
        .long_sum  (long_sum),
        .stat      (win_stat)
    );

    assign div_dividend = div_sel_long ? long_sum : short_sum;
    assign div_divisor = div_sel_long ? l_eff : s_eff;

    dmac_serial_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Equal quotients leave the remainders to settle the exact comparison
    // ra/s > rb/l, done by cross-multiplying.
    always_comb
    begin
        cross_a = {{dmac_pkg::EFF_BITS{1'b0}}, ra_reg} * {{dmac_pkg::EFF_BITS{1'b0}}, l_eff};
        cross_b = {{dmac_pkg::EFF_BITS{1'b0}}, rb_reg} * {{dmac_pkg::EFF_BITS{1'b0}}, s_eff};
        if (qa_reg != qb_reg)
        begin
            buy_next = (qa_reg > qb_reg);
        end
        else
        begin
            buy_next = (cross_a > cross_b);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            short_avg_reg <= qa_reg[dmac_pkg::PRICE_BITS-1:0];
            long_avg_reg <= qb_reg[dmac_pkg::PRICE_BITS-1:0];
            buy_reg <= buy_next;
            out_tag_reg <= tag_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign short_average = short_avg_reg;
    assign long_average = long_avg_reg;
    assign buy_signal = buy_reg;
    assign out_tag = out_tag_reg;

endmodule

>>> design/dmac_checker.sv
// Port-level assertions for the crossover unit and the bind that attaches them.
module dmac_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [dmac_pkg::PRICE_BITS-1:0]     short_average,
    input logic [dmac_pkg::PRICE_BITS-1:0]     long_average,
    input logic                                buy_signal,
    input logic [dmac_pkg::TAG_BITS-1:0]       out_tag
);

    // A result beat that is held back keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(short_average) &&
        $stable(long_average) && $stable(buy_signal) && $stable(out_tag))
        else $error("result changed while stalled");

    // One price is worked on at a time, so taking a beat closes the input.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a price is in progress");

    // A new result is loaded only at the end of a price's work, never while idle.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while the unit was idle");

    // The result register is not reloaded right after a price is taken.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid || $stable(out_tag))
        else $error("result loaded too soon after an input beat");

endmodule

bind dual_moving_average_crossover_unit dmac_checker u_checker (.*);

>>> test/dual_moving_average_crossover_unit_tb.sv
// Self-checking testbench for the dual moving average crossover unit.
`timescale 1ns / 100ps

module dual_moving_average_crossover_unit_tb;

    localparam int RESET_CYCLES = 7;
    localparam int SETTLE_CYCLES = 48;
    localparam int DRAIN_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [dmac_pkg::PRICE_BITS-1:0] PRICE_MAX = '1;
    localparam logic [dmac_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED =
        dmac_pkg::CFG_INDEX_BITS'(15);

    typedef struct packed {
        logic [dmac_pkg::PRICE_BITS-1:0] short_average;
        logic [dmac_pkg::PRICE_BITS-1:0] long_average;
        logic                            buy_signal;
        logic [dmac_pkg::TAG_BITS-1:0]   out_tag;
    } crossover_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic [dmac_pkg::PRICE_BITS-1:0]     close_price = '0;
    logic [dmac_pkg::TAG_BITS-1:0]       tag = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic [dmac_pkg::PRICE_BITS-1:0]     short_average;
    logic [dmac_pkg::PRICE_BITS-1:0]     long_average;
    logic                                buy_signal;
    logic [dmac_pkg::TAG_BITS-1:0]       out_tag;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [dmac_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [dmac_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

    // Shadow state of the crossover unit.
    logic [dmac_pkg::LEN_BITS-1:0]   short_len_reg = dmac_pkg::SHORT_LEN_RESET;
    logic [dmac_pkg::LEN_BITS-1:0]   long_len_reg = dmac_pkg::LONG_LEN_RESET;
    logic [dmac_pkg::PRICE_BITS-1:0] price_ring [dmac_pkg::MAX_WINDOW];
    longint unsigned                 short_total = 0;
    longint unsigned                 long_total = 0;
    int unsigned                     ring_ptr = 0;
    int unsigned                     ring_count = 0;

    crossover_t expected_crossovers [$];
    int         mismatch_count = 0;
    bit         sender_idle = 1'b1;
    bit         receiver_idle = 1'b1;
    bit         hold_request = 1'b0;

    dual_moving_average_crossover_unit i_dut (.*);

    always #5 clk = ~clk;

    function automatic void track_price(input logic [dmac_pkg::PRICE_BITS-1:0] price,
                                        input logic [dmac_pkg::TAG_BITS-1:0] date_tag);
        int unsigned span_long;
        int unsigned span_short;
        crossover_t  result;
        span_long = (long_len_reg == 0) ? 1 :
                    (long_len_reg > dmac_pkg::MAX_WINDOW) ? dmac_pkg::MAX_WINDOW :
                    long_len_reg;
        span_short = (short_len_reg == 0) ? 1 :
                     (short_len_reg > span_long) ? span_long : short_len_reg;
        if (ring_count >= span_short)
            short_total -= price_ring[(ring_ptr + dmac_pkg::MAX_WINDOW - span_short)
                                      % dmac_pkg::MAX_WINDOW];
        if (ring_count >= span_long)
            long_total -= price_ring[(ring_ptr + dmac_pkg::MAX_WINDOW - span_long)
                                     % dmac_pkg::MAX_WINDOW];
        short_total += price;
        long_total += price;
        price_ring[ring_ptr] = price;
        ring_ptr = (ring_ptr + 1) % dmac_pkg::MAX_WINDOW;
        if (ring_count < span_long)
            ring_count++;
        if (ring_count >= span_long)
        begin
            result.short_average = dmac_pkg::PRICE_BITS'(short_total / span_short);
            result.long_average = dmac_pkg::PRICE_BITS'(long_total / span_long);
            // Cross-multiplied sums decide the flag exactly; ties are a sell.
            result.buy_signal = (short_total * span_long) > (long_total * span_short);
            result.out_tag = date_tag;
            expected_crossovers.push_back(result);
        end
    endfunction

    function automatic logic [dmac_pkg::PRICE_BITS-1:0] random_price();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return PRICE_MAX;
            2: return dmac_pkg::PRICE_BITS'($urandom_range(0, 255));
            default: return dmac_pkg::PRICE_BITS'($urandom);
        endcase
    endfunction

    task automatic drain_results();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (expected_crossovers.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_crossovers.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_crossovers.size());
            mismatch_count++;
            expected_crossovers.delete();
        end
        // A price that only fills the window may still be in flight.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [dmac_pkg::CFG_INDEX_BITS-1:0] index,
                             input logic [dmac_pkg::CFG_DATA_BITS-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == dmac_pkg::REG_SHORT_LEN)
            short_len_reg = value[dmac_pkg::LEN_BITS-1:0];
        if (index == dmac_pkg::REG_LONG_LEN)
            long_len_reg = value[dmac_pkg::LEN_BITS-1:0];
        if (index == dmac_pkg::REG_SHORT_LEN || index == dmac_pkg::REG_LONG_LEN)
        begin
            short_total = 0;
            long_total = 0;
            ring_ptr = 0;
            ring_count = 0;
        end
    endtask

    task automatic send_price(input logic [dmac_pkg::PRICE_BITS-1:0] price,
                              input logic [dmac_pkg::TAG_BITS-1:0] date_tag);
        int gap;
        gap = sender_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        close_price <= price;
        tag <= date_tag;
        do @(posedge clk); while (!in_ready);
        track_price(price, date_tag);
    endtask

    task automatic test_reset_lengths();
        sender_idle = 1'b1;
        receiver_idle = 1'b1;
        repeat (205) send_price(random_price(), $urandom);
    endtask

    task automatic test_directed_cases();
        int i;
        // Bits above the nine-bit length field must be dropped.
        write_reg(dmac_pkg::REG_LONG_LEN, 16'hFE03);
        write_reg(dmac_pkg::REG_SHORT_LEN, 16'h0002);
        send_price('0, '0);
        send_price(PRICE_MAX, '1);
        send_price(PRICE_MAX, 32'h8000_0001);
        for (i = 0; i < 3; i++)
            send_price('0, 32'h0000_0100 + i);
        for (i = 0; i < 3; i++)
            send_price(dmac_pkg::PRICE_BITS'(7), 32'h0000_0200 + i);
        send_price(dmac_pkg::PRICE_BITS'(1), 32'h0000_0300);
        send_price(dmac_pkg::PRICE_BITS'(2), 32'h0000_0301);
        // An unknown index leaves the stream running.
        write_reg(REG_UNUSED, 16'h0001);
        send_price(dmac_pkg::PRICE_BITS'(5), 32'h0000_0400);
        send_price(PRICE_MAX, 32'h0000_0401);
        // Short window longer than the long one collapses onto it.
        write_reg(dmac_pkg::REG_SHORT_LEN, 16'd300);
        write_reg(dmac_pkg::REG_LONG_LEN, 16'd4);
        for (i = 0; i < 6; i++)
            send_price(dmac_pkg::PRICE_BITS'(100 * (i + 1)), 32'h0000_0500 + i);
        // Zero lengths are raised to one.
        write_reg(dmac_pkg::REG_LONG_LEN, 16'd0);
        write_reg(dmac_pkg::REG_SHORT_LEN, 16'd0);
        for (i = 0; i < 3; i++)
            send_price(random_price(), $urandom);
    endtask

    task automatic test_full_windows();
        int i;
        write_reg(dmac_pkg::REG_LONG_LEN, 16'h01FF);
        write_reg(dmac_pkg::REG_SHORT_LEN, 16'h0100);
        for (i = 0; i < 262; i++)
            send_price((i < 258) ? PRICE_MAX : random_price(), $urandom);
    endtask

    task automatic test_output_backpressure();
        write_reg(dmac_pkg::REG_LONG_LEN, 16'd2);
        write_reg(dmac_pkg::REG_SHORT_LEN, 16'd1);
        sender_idle = 1'b0;
        receiver_idle = 1'b0;
        hold_request = 1'b1;
        repeat (30) send_price(random_price(), $urandom);
        sender_idle = 1'b1;
        receiver_idle = 1'b1;
    endtask

    task automatic test_random_lengths();
        int sent;
        int win_long;
        int win_short;
        int count;
        sent = 0;
        while (sent < 260)
        begin
            case ($urandom_range(0, 9))
                0: win_long = $urandom_range(13, 40);
                1: win_long = 0;
                default: win_long = $urandom_range(1, 12);
            endcase
            win_short = $urandom_range(0, win_long + 3);
            if ($urandom_range(0, 1))
            begin
                write_reg(dmac_pkg::REG_LONG_LEN, {7'($urandom), 9'(win_long)});
                write_reg(dmac_pkg::REG_SHORT_LEN, {7'($urandom), 9'(win_short)});
            end
            else
            begin
                write_reg(dmac_pkg::REG_SHORT_LEN, {7'($urandom), 9'(win_short)});
                write_reg(dmac_pkg::REG_LONG_LEN, {7'($urandom), 9'(win_long)});
            end
            if ($urandom_range(0, 4) == 0)
                write_reg(REG_UNUSED, dmac_pkg::CFG_DATA_BITS'($urandom));
            sender_idle = ($urandom_range(0, 3) != 0);
            receiver_idle = ($urandom_range(0, 3) != 0);
            count = ((win_long == 0) ? 1 : win_long) + $urandom_range(5, 25);
            repeat (count) send_price(random_price(), $urandom);
            sent += count;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        crossover_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_crossovers.size() == 0)
            begin
                $error("result beat with no expectation, tag %h", out_tag);
                mismatch_count++;
            end
            else
            begin
                want = expected_crossovers.pop_front();
                if (short_average !== want.short_average)
                begin
                    $error("short_average: expected %0d, got %0d",
                           want.short_average, short_average);
                    mismatch_count++;
                end
                if (long_average !== want.long_average)
                begin
                    $error("long_average: expected %0d, got %0d",
                           want.long_average, long_average);
                    mismatch_count++;
                end
                if (buy_signal !== want.buy_signal)
                begin
                    $error("buy_signal: expected %b, got %b", want.buy_signal, buy_signal);
                    mismatch_count++;
                end
                if (out_tag !== want.out_tag)
                begin
                    $error("out_tag: expected %h, got %h", want.out_tag, out_tag);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : result_sink
        int gap;
        wait (rst_n);
        forever
        begin
            // A long hold lets the unit fill up and stall its input side.
            if (hold_request)
            begin
                gap = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else
                gap = receiver_idle ? $urandom_range(0, 14) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_lengths();
        test_directed_cases();
        test_full_windows();
        test_output_backpressure();
        test_random_lengths();
        drain_results();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> dual_moving_average_crossover_unit.f
design/dmac_pkg.sv
design/dmac_serial_div.sv
design/dmac_window.sv
design/dual_moving_average_crossover_unit.sv
design/dmac_checker.sv
test/dual_moving_average_crossover_unit_tb.sv
